>>> sv/lphtab_pkg.sv
package lphtab_pkg;

   localparam int TABLE_SIZE_DEF = 1024;
   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int SLOT_W = 10;
   localparam int ENT_W  = 1 + KEY_W + DATA_W;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      op_type              req_type;
      logic [KEY_W-1:0]    key_value;
      logic [DATA_W-1:0]   data_value;
   } req_item_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot_index;
      logic [DATA_W-1:0]   data_out;
   } rsp_item_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [DATA_W-1:0]   data;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic       accept;
      logic       clr_start;
      logic       clr_step;
      logic       hash_start;
      logic       hash_ent;
      logic       load_home;
      logic       rd_en;
      logic       advance;
      logic       wr_insert;
      logic       wr_hole;
      logic       wr_copy;
      logic       set_result;
      status_type res_status;
      logic       res_slot;
      logic       res_data;
      logic       rsp_load;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   hash_done;
      logic   rd_valid;
      logic   key_match;
      logic   probe_last;
      logic   inner_max;
      logic   stays;
      logic   guard_ok;
      logic   clr_last;
      logic   rsp_free;
   } dp_stat_type;

endpackage

>>> sv/lphtab_ram.sv
module lphtab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lphtab_hash.sv
module lphtab_hash
   import lphtab_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_W-1:0]              key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] home
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam logic [AW:0] N_C = (AW+1)'(TABLE_SIZE);
   localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

   logic [AW-1:0]    rem_ff, rem_in;
   logic             done_ff, done_in;

   generate
      if (IS_POW2) begin : g_mask
         always_comb begin
            rem_in  = rem_ff;
            done_in = start;
            if (start) begin
               rem_in = key[AW-1:0];
            end
         end
      end else begin : g_recip
         // home = key - floor(key * M / 2^(KEY_W+AW)) * TABLE_SIZE, M the rounded-up
         // reciprocal; exact for every key; prod_ff, qn_ff, rem_ff registered in turn
         localparam int PW = 2 * KEY_W + 1;
         localparam logic [KEY_W:0] M_C = (KEY_W+1)'(((PW'(1) << (KEY_W + AW)) +
                                          PW'(TABLE_SIZE - 1)) / PW'(TABLE_SIZE));

         logic [KEY_W-1:0] opd_ff, opd_in;
         logic [PW-1:0]    prod_ff, prod_in;
         logic [KEY_W-1:0] qn_ff, qn_in;
         logic             p1_ff, p2_ff;
         logic [PW-1:0]    quo;
         logic [KEY_W-1:0] diff;

         always_comb begin
            quo     = prod_ff >> (KEY_W + AW);
            diff    = opd_ff - qn_ff;
            opd_in  = opd_ff;
            prod_in = prod_ff;
            qn_in   = quo[KEY_W-1:0] * KEY_W'(TABLE_SIZE);
            rem_in  = rem_ff;
            done_in = p2_ff;
            if (start) begin
               opd_in  = key;
               prod_in = PW'(key) * PW'(M_C);
            end
            if (p2_ff) begin
               rem_in = diff[AW-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               p1_ff <= 1'b0;
               p2_ff <= 1'b0;
            end else begin
               p1_ff <= start;
               p2_ff <= p1_ff;
            end
            opd_ff  <= opd_in;
            prod_ff <= prod_in;
            qn_ff   <= qn_in;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

   a_home_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (AW+1)'(rem_ff) < N_C)
      else $error("hash result out of table range");

endmodule

>>> sv/lphtab_ctrl.sv
module lphtab_ctrl
   import lphtab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  op_type      req_op,
   output logic        req_stall,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [11:0] {
      S_INIT  = 12'b0000_0000_0001,
      S_IDLE  = 12'b0000_0000_0010,
      S_CLEAR = 12'b0000_0000_0100,
      S_HASH  = 12'b0000_0000_1000,
      S_RD    = 12'b0000_0001_0000,
      S_CHK   = 12'b0000_0010_0000,
      S_HOLE  = 12'b0000_0100_0000,
      S_DRD   = 12'b0000_1000_0000,
      S_DCHK  = 12'b0001_0000_0000,
      S_DHASH = 12'b0010_0000_0000,
      S_COPY  = 12'b0100_0000_0000,
      S_RESP  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_status = ST_OK;
      case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == OP_CLEAR) begin
                  cmd.clr_start = 1'b1;
                  state_in = S_CLEAR;
               end else begin
                  cmd.hash_start = 1'b1;
                  state_in = S_HASH;
               end
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               cmd.set_result = 1'b1;
               state_in = S_RESP;
            end
         end
         S_HASH: begin
            if (stat.hash_done) begin
               cmd.load_home = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!stat.rd_valid) begin
               cmd.set_result = 1'b1;
               if (stat.op == OP_INSERT) begin
                  cmd.wr_insert = 1'b1;
                  cmd.res_slot  = 1'b1;
               end else begin
                  cmd.res_status = ST_NOT_FOUND;
               end
               state_in = S_RESP;
            end else if (stat.key_match) begin
               cmd.set_result = 1'b1;
               cmd.res_slot   = 1'b1;
               if (stat.op == OP_INSERT) begin
                  cmd.res_status = ST_DUPLICATE;
               end else begin
                  cmd.res_data = 1'b1;
               end
               state_in = (stat.op == OP_DELETE) ? S_HOLE : S_RESP;
            end else if (stat.probe_last) begin
               cmd.set_result = 1'b1;
               cmd.res_status = (stat.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_RD;
            end
         end
         S_HOLE: begin
            cmd.wr_hole = 1'b1;
            state_in = S_DRD;
         end
         S_DRD: begin
            cmd.rd_en = 1'b1;
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (!stat.rd_valid) begin
               state_in = S_RESP;
            end else if (stat.inner_max) begin
               state_in = S_COPY;
            end else begin
               cmd.hash_start = 1'b1;
               cmd.hash_ent   = 1'b1;
               state_in = S_DHASH;
            end
         end
         S_DHASH: begin
            if (stat.hash_done) begin
               if (stat.stays) begin
                  cmd.advance = 1'b1;
                  state_in = S_DRD;
               end else begin
                  state_in = S_COPY;
               end
            end
         end
         S_COPY: begin
            cmd.wr_copy = 1'b1;
            state_in = stat.guard_ok ? S_HOLE : S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_copy_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> $past(state_ff) == S_DCHK || $past(state_ff) == S_DHASH)
      else $error("entry move without a chain check");

   a_hole_after_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK && state_in == S_HOLE) |-> stat.op == OP_DELETE && stat.key_match)
      else $error("repair started without a delete hit");

endmodule

>>> sv/lphtab_dp.sv
module lphtab_dp
   import lphtab_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  ctl_cmd_type  cmd,
   input  req_item_type req_data,
   output dp_stat_type  stat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam logic [AW:0]   N_C   = (AW+1)'(TABLE_SIZE);
   localparam logic [AW-1:0] TOP_C = AW'(TABLE_SIZE - 1);

   op_type            op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] data_ff;
   logic [AW-1:0]     i_ff, i_in, j_ff, j_in, clr_ff, clr_in;
   logic [AW:0]       n_ff, n_in, g_ff, g_in;
   rsp_item_type      res_ff, res_in;
   rsp_item_type      out_ff;
   logic              out_valid_ff, out_valid_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_word;
   entry_type         rd_word;
   logic [ENT_W-1:0]  rd_raw;
   logic [AW-1:0]     i_next;
   logic              hash_done;
   logic [AW-1:0]     home;
   logic [AW+SLOT_W-1:0] slot_wide;

   lphtab_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (cmd.rd_en),
      .rd_addr (i_ff),
      .rd_data (rd_raw)
   );

   assign rd_word = entry_type'(rd_raw);

   lphtab_hash #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (cmd.hash_start),
      .key   (cmd.hash_ent ? rd_word.key : req_data.key_value),
      .done  (hash_done),
      .home  (home)
   );

   assign i_next    = (i_ff == '0) ? TOP_C : i_ff - 1'b1;
   assign slot_wide = (AW+SLOT_W)'(i_ff);

   // table write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff;
      wr_word = '0;
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
      end else if (cmd.wr_insert) begin
         wr_en   = 1'b1;
         wr_word = '{valid: 1'b1, key: key_ff, data: data_ff};
      end else if (cmd.wr_hole) begin
         wr_en   = 1'b1;
      end else if (cmd.wr_copy) begin
         wr_en   = 1'b1;
         wr_addr = j_ff;
         wr_word = '{valid: 1'b1, key: rd_word.key, data: rd_word.data};
      end
   end

   always_comb begin
      i_in   = i_ff;
      j_in   = j_ff;
      n_in   = n_ff;
      g_in   = g_ff;
      clr_in = clr_ff;
      res_in = res_ff;
      if (cmd.clr_start) begin
         clr_in = '0;
      end else if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.load_home) begin
         i_in = home;
         n_in = '0;
         g_in = '0;
      end else if (cmd.advance) begin
         i_in = i_next;
         n_in = n_ff + 1'b1;
      end else if (cmd.wr_hole) begin
         j_in = i_ff;
         i_in = i_next;
         n_in = '0;
      end
      if (cmd.wr_copy) begin
         g_in = g_ff + 1'b1;
      end
      if (cmd.set_result) begin
         res_in.status     = cmd.res_status;
         res_in.slot_index = cmd.res_slot ? slot_wide[SLOT_W-1:0] : '0;
         res_in.data_out   = cmd.res_data ? rd_word.data : '0;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.rsp_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         clr_ff       <= clr_in;
      end
      if (cmd.accept) begin
         op_ff   <= req_data.req_type;
         key_ff  <= req_data.key_value;
         data_ff <= req_data.data_value;
      end
      if (cmd.rsp_load) begin
         out_ff <= res_ff;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      n_ff   <= n_in;
      g_ff   <= g_in;
      res_ff <= res_in;
   end

   always_comb begin
      stat.op         = op_ff;
      stat.hash_done  = hash_done;
      stat.rd_valid   = rd_word.valid;
      stat.key_match  = (rd_word.key == key_ff);
      stat.probe_last = (n_ff == N_C - 2'd2);
      stat.inner_max  = (n_ff == N_C);
      // entry at i keeps its place if its home lies cyclically in [i, j)
      stat.stays      = ((i_ff <= home) && (home < j_ff)) ||
                        ((i_ff > j_ff) && ((i_ff <= home) || (home < j_ff)));
      stat.guard_ok   = (g_ff < N_C);
      stat.clr_last   = (clr_ff == TOP_C);
      stat.rsp_free   = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !cmd.rd_en)
      else $error("table read and write in one cycle");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(cmd.rsp_load))
      else $error("result beat without a load");

endmodule

>>> sv/linear_probe_hash_table_core.sv
// Find, insert and delete hash the key to its home slot, then read one slot per probe; a
//   delete then writes a hole and reads and rehashes the entries that follow until an
//   empty slot, moving an entry into the hole when its home lies outside the gap.
// Requests: one at a time; the next one can be accepted in the cycle after the beat is loaded;
//   a clear sweeps all N slots. A stalled beat holds the next.
// Reset: synchronous, active high; then a clearing pass over every slot with req_stall high.
module linear_probe_hash_table_core
   import lphtab_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   // The controller sequences probe reads, inserts and the backward-shift
   // repair of a delete; the datapath owns the slot memory (valid, key, data
   // in one word), the home-slot unit, the probe pointers and the output beat.
   ctl_cmd_type cmd;
   dp_stat_type stat;

   lphtab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.req_type),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the result in the output register so the next request can be
   // accepted while the previous beat waits on rsp_stall.
   lphtab_dp #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
